// ----- rtl/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// Register indexes, register widths and reset values, and the result record
// passed from the measurement core to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package uer_pkg;

  // Default build constants
  localparam int SOUND_FACTOR_DEF = 58;
  localparam int WIDTH_BITS_DEF   = 16;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_PULSE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_THR  = 3'd4;

  // Register widths
  localparam int PULSE_W   = 6;
  localparam int TIMEOUT_W = 15;
  localparam int CM_W      = 9;

  // Register reset values
  localparam logic [PULSE_W-1:0]   PULSE_RST   = 6'd10;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 15'd25000;
  localparam int                   MIN_CM_RST  = 2;
  localparam int                   MAX_CM_RST  = 400;
  localparam logic [CM_W-1:0]      THR_CM_RST  = 9'd20;

  // Result and counter widths
  localparam int                   DIST_W   = 15;
  localparam logic [TIMEOUT_W-1:0] WAIT_MAX = 15'h7FFF;

  // Stream payload widths, padded to whole bytes
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 24;

  // Fixed-width part of the configuration
  typedef struct packed {
    logic [PULSE_W-1:0]   trigger_pulse;
    logic [TIMEOUT_W-1:0] timeout;
    logic [CM_W-1:0]      obstacle_thr;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic              obstacle;
    logic              distance_valid;
    logic [DIST_W-1:0] distance_q4;
    logic              timed_out;
    logic              measurement_done;
    logic              busy_res;
    logic              trigger_out;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/uer_cfg.sv -----
// ----------------------------------------------------------------------------
// uer_cfg: configuration registers
// Holds the pulse length, timeout and obstacle threshold, and keeps the range
// limits already scaled to echo ticks (centimetres times the sound factor).
// ----------------------------------------------------------------------------
`default_nettype none

module uer_cfg #(
  parameter int SOUND_FACTOR = uer_pkg::SOUND_FACTOR_DEF,
  parameter int LIM_W        = uer_pkg::CM_W + $clog2(SOUND_FACTOR + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output      uer_pkg::cfg_t                   cfg,
  output      logic [LIM_W-1:0]                min_lim,
  output      logic [LIM_W-1:0]                max_lim
);

  // Capture register writes; scale range limits at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_pulse <= uer_pkg::PULSE_RST;
      cfg.timeout       <= uer_pkg::TIMEOUT_RST;
      cfg.obstacle_thr  <= uer_pkg::THR_CM_RST;
      min_lim           <= LIM_W'(uer_pkg::MIN_CM_RST * SOUND_FACTOR);
      max_lim           <= LIM_W'(uer_pkg::MAX_CM_RST * SOUND_FACTOR);
    end else if (cfg_we) begin
      case (cfg_index)
        uer_pkg::CFG_TRIGGER_PULSE: begin
          cfg.trigger_pulse <= cfg_wdata[uer_pkg::PULSE_W-1:0];
        end
        uer_pkg::CFG_TIMEOUT: begin
          cfg.timeout <= cfg_wdata[uer_pkg::TIMEOUT_W-1:0];
        end
        uer_pkg::CFG_MIN_DISTANCE: begin
          min_lim <= LIM_W'(cfg_wdata[uer_pkg::CM_W-1:0] * SOUND_FACTOR);
        end
        uer_pkg::CFG_MAX_DISTANCE: begin
          max_lim <= LIM_W'(cfg_wdata[uer_pkg::CM_W-1:0] * SOUND_FACTOR);
        end
        uer_pkg::CFG_OBSTACLE_THR: begin
          cfg.obstacle_thr <= cfg_wdata[uer_pkg::CM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/uer_core.sv -----
// ----------------------------------------------------------------------------
// uer_core: per-tick measurement state
// Tracks echo edges, the echo width with a running quotient and remainder of
// width*16/SOUND_FACTOR, the trigger pulse and the timeout, and forms the
// result of each tick in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module uer_core #(
  parameter int SOUND_FACTOR = uer_pkg::SOUND_FACTOR_DEF,
  parameter int WIDTH_BITS   = uer_pkg::WIDTH_BITS_DEF,
  parameter int LIM_W        = uer_pkg::CM_W + $clog2(SOUND_FACTOR + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic              start_request,
  input  wire logic              echo_level,
  input  wire uer_pkg::cfg_t     cfg,
  input  wire logic [LIM_W-1:0]  min_lim,
  input  wire logic [LIM_W-1:0]  max_lim,
  output      uer_pkg::result_t  res
);

  localparam int RW = (SOUND_FACTOR > 1) ? $clog2(SOUND_FACTOR) : 1;
  localparam int CW = (WIDTH_BITS > LIM_W) ? WIDTH_BITS : LIM_W;
  localparam int DW = uer_pkg::DIST_W;

  // Quotient and remainder of 16 / SOUND_FACTOR: one width tick
  localparam logic [DW-1:0] Q_STEP   = DW'(16 / SOUND_FACTOR);
  localparam logic [DW-1:0] Q_STEP1  = DW'(16 / SOUND_FACTOR + 1);
  localparam logic [RW:0]   R_STEP   = (RW + 1)'(16 % SOUND_FACTOR);
  localparam logic [RW:0]   SF_WIDE  = (RW + 1)'(SOUND_FACTOR);

  logic                         echo_prev, echo_prev_next;
  logic                         measuring, measuring_next;
  logic [uer_pkg::PULSE_W-1:0]  trig_count, trig_count_next;
  logic [uer_pkg::TIMEOUT_W-1:0] wait_count, wait_count_next;
  logic [WIDTH_BITS-1:0]        width, width_next;
  logic [DW-1:0]                quot, quot_next;
  logic [RW-1:0]                rem, rem_next;
  logic [DW-1:0]                last_dist, last_dist_next;
  logic                         last_valid, last_valid_next;

  logic                         rise, high, fell, started, tmo, in_range;
  logic [RW:0]                  rem_sum;
  logic [uer_pkg::TIMEOUT_W-1:0] wait_inc;
  logic [uer_pkg::PULSE_W-1:0]  trig_eff;
  logic [CW-1:0]                width_x;

  // Next state and result of one tick
  always_comb begin
    rise    = echo_level & ~echo_prev;
    high    = echo_level & echo_prev;
    fell    = ~echo_level & echo_prev;
    started = start_request & ~measuring;

    echo_prev_next  = echo_level;
    width_next      = width;
    quot_next       = quot;
    rem_next        = rem;
    last_dist_next  = last_dist;
    last_valid_next = last_valid;
    measuring_next  = measuring;
    wait_count_next = wait_count;
    tmo             = 1'b0;

    // Width counter with running quotient
    rem_sum = {1'b0, rem} + R_STEP;
    if (rise) begin
      width_next = WIDTH_BITS'(1);
      quot_next  = Q_STEP;
      rem_next   = RW'(R_STEP);
    end else if (high && (width != '1)) begin
      width_next = width + WIDTH_BITS'(1);
      if (rem_sum >= SF_WIDE) begin
        quot_next = quot + Q_STEP1;
        rem_next  = RW'(rem_sum - SF_WIDE);
      end else begin
        quot_next = quot + Q_STEP;
        rem_next  = RW'(rem_sum);
      end
    end

    // Range check and store on a falling edge
    width_x  = CW'(width);
    in_range = (width_x >= CW'(min_lim)) && (width_x <= CW'(max_lim));
    if (fell) begin
      last_dist_next  = in_range ? quot : '0;
      last_valid_next = in_range;
      measuring_next  = 1'b0;
    end

    // Timeout while busy
    wait_inc = (wait_count < uer_pkg::WAIT_MAX) ? wait_count + 1'b1 : wait_count;
    if (!fell && measuring) begin
      wait_count_next = wait_inc;
      if (wait_inc >= cfg.timeout) begin
        tmo             = 1'b1;
        measuring_next  = 1'b0;
        last_dist_next  = '0;
        last_valid_next = 1'b0;
      end
    end

    // Start and trigger pulse
    if (started) begin
      measuring_next  = 1'b1;
      wait_count_next = '0;
    end
    trig_eff        = started ? cfg.trigger_pulse : trig_count;
    trig_count_next = (trig_eff != '0) ? trig_eff - 1'b1 : trig_eff;

    res.trigger_out      = (trig_eff != '0);
    res.busy_res         = measuring_next;
    res.measurement_done = fell | tmo;
    res.timed_out        = tmo;
    res.distance_q4      = last_dist_next;
    res.distance_valid   = last_valid_next;
    res.obstacle         = last_valid_next && (last_dist_next != '0) &&
                           (last_dist_next < DW'({cfg.obstacle_thr, 4'b0000}));
  end

  // Commit state when an item is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_prev  <= 1'b0;
      measuring  <= 1'b0;
      trig_count <= '0;
      wait_count <= '0;
      width      <= '0;
      quot       <= '0;
      rem        <= '0;
      last_dist  <= '0;
      last_valid <= 1'b0;
    end else if (step) begin
      echo_prev  <= echo_prev_next;
      measuring  <= measuring_next;
      trig_count <= trig_count_next;
      wait_count <= wait_count_next;
      width      <= width_next;
      quot       <= quot_next;
      rem        <= rem_next;
      last_dist  <= last_dist_next;
      last_valid <= last_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ultrasonic_echo_ranger.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: echo-pulse ranging controller
// Drives the trigger pulse, times the echo and reports distance in 1/16 cm.
// ----------------------------------------------------------------------------
// One transaction in per microsecond tick, one result transaction out per
// tick. The block takes a new tick every clock cycle unless a held result
// stalls it; each tick passes through the input register, then the result
// register. A held result lets one more tick into the input register and
// then holds the input side until the result is taken. The per-tick work
// is one pass of counters and compares: the distance is kept as a running
// quotient and remainder of width*16/SOUND_FACTOR, so no divider sits in
// the path, and range limits are scaled by the sound factor when they are
// written. Configuration writes take effect on the next cycle; there is no
// clearing pass after reset.
`default_nettype none

module ultrasonic_echo_ranger #(
  parameter int SOUND_FACTOR = uer_pkg::SOUND_FACTOR_DEF,
  parameter int WIDTH_BITS   = uer_pkg::WIDTH_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // tdata: [0] start_request, [1] echo_level, [7:2] zero
  input  wire logic                            s_tvalid,
  output      logic                            s_tready,
  input  wire logic [uer_pkg::S_TDATA_W-1:0]   s_tdata,
  // tdata: [0] trigger_out, [1] busy_res, [2] measurement_done, [3] timed_out,
  //        [18:4] distance_q4, [19] distance_valid, [20] obstacle, [23:21] zero
  output      logic                            m_tvalid,
  input  wire logic                            m_tready,
  output      logic [uer_pkg::M_TDATA_W-1:0]   m_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int LIM_W = uer_pkg::CM_W + $clog2(SOUND_FACTOR + 1);

  uer_pkg::cfg_t    cfg;
  logic [LIM_W-1:0] min_lim, max_lim;
  uer_pkg::result_t res_comb, res;

  logic in_valid, in_start, in_echo;
  logic advance;

  // Move an item forward when the result register is free or being drained
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_start <= s_tdata[0];
      in_echo  <= s_tdata[1];
    end
  end

  uer_cfg #(
    .SOUND_FACTOR (SOUND_FACTOR),
    .LIM_W        (LIM_W)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .min_lim   (min_lim),
    .max_lim   (max_lim)
  );

  uer_core #(
    .SOUND_FACTOR (SOUND_FACTOR),
    .WIDTH_BITS   (WIDTH_BITS),
    .LIM_W        (LIM_W)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .start_request (in_start),
    .echo_level    (in_echo),
    .cfg           (cfg),
    .min_lim       (min_lim),
    .max_lim       (max_lim),
    .res           (res_comb)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign m_tdata = {3'b000, res};

endmodule

`default_nettype wire
